// ===== rtl/vfma_pkg.sv =====
// Shared types, constants and helpers of the vector fused multiply-add unit.
// Depends on nothing; every other file of the unit imports it.
package vfma_pkg;

  // Adder frame: carry bit, addend mantissa, two gap bits, product, two guard bits
  localparam int FrameW    = 164;
  localparam int ProdW     = 106;
  localparam int MantW     = 53;
  localparam int ExpW      = 14;
  localparam int ChunkW    = 16;
  localparam int NumChunks = 11;
  localparam int PadW      = ChunkW * NumChunks;

  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] InfMag   = 63'h7FF0_0000_0000_0000;
  localparam logic [10:0] ExpOnes  = 11'h7FF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OPERATION = 2'd0,
    REG_BROADCAST = 2'd1,
    REG_SCALAR_A  = 2'd2,
    REG_SCALAR_B  = 2'd3
  } cfg_reg_e;

  // Bit positions inside the operation and broadcast registers
  localparam int OpNegAddendBit  = 0;
  localparam int OpNegProductBit = 1;
  localparam int BcastBBit       = 0;
  localparam int BcastABit       = 1;

  // Result decided early, bypassing the arithmetic path
  typedef struct packed {
    logic        hit;
    logic [63:0] bits;
  } spec_t;

  // Product and alignment controls, multiplier to adder
  typedef struct packed {
    spec_t                  spec;
    logic                   ps;
    logic                   bs;
    logic                   eff_sub;
    logic                   bz;
    logic                   clamp;
    logic [ProdW-1:0]       prod;
    logic [MantW-1:0]       mb;
    logic [7:0]             sh_b;
    logic [6:0]             sh_p;
    logic signed [ExpW-1:0] fe;
  } prod_t;

  // Exact sum magnitude, adder to normaliser
  typedef struct packed {
    spec_t                  spec;
    logic                   sign;
    logic                   st;
    logic signed [ExpW-1:0] fe;
    logic [FrameW-1:0]      mag;
  } sum_t;

  // Normalised frame, normaliser to rounder
  typedef struct packed {
    spec_t                  spec;
    logic                   sign;
    logic                   st;
    logic                   zero;
    logic signed [ExpW-1:0] efield;
    logic [FrameW-1:0]      frame;
  } norm_t;

  // Leading zeros of a nonzero 16-bit chunk
  function automatic logic [3:0] lzc16(input logic [ChunkW-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < ChunkW; i++) begin
      if (v[i]) n = 4'(ChunkW - 1 - i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/vfma_mul.sv =====
// Operand unpack, special-case decode and split 53x53 multiplier (two stages).
// Depends on vfma_pkg.
module vfma_mul import vfma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] x_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [1:0]  op_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output prod_t       out_o
);

  typedef struct packed {
    spec_t            spec;
    logic             ps;
    logic             bs;
    logic             bz;
    logic [MantW-1:0] mb;
    logic [10:0]      ex;
    logic [10:0]      ea;
    logic [10:0]      eb;
    logic [53:0]      ll;
    logic [52:0]      lh;
    logic [52:0]      hl;
    logic [51:0]      hh;
  } s1_t;

  logic  v1_q, v2_q, en1, en2;
  s1_t   s1_d, s1_q;
  prod_t s2_d, s2_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Unpack and classify
  logic [10:0]      xe, ae, be;
  logic [51:0]      xf, af, bf;
  logic             xz, az, bz, xi, ai, bi, anynan, ps, bs;
  logic [MantW-1:0] mx, ma;

  always_comb begin
    xe = x_i[62:52]; ae = a_i[62:52]; be = b_i[62:52];
    xf = x_i[51:0];  af = a_i[51:0];  bf = b_i[51:0];
    xz = (xe == 11'd0) && (xf == 52'd0);
    az = (ae == 11'd0) && (af == 52'd0);
    bz = (be == 11'd0) && (bf == 52'd0);
    xi = (xe == ExpOnes) && (xf == 52'd0);
    ai = (ae == ExpOnes) && (af == 52'd0);
    bi = (be == ExpOnes) && (bf == 52'd0);
    anynan = ((xe == ExpOnes) && (xf != 52'd0)) || ((ae == ExpOnes) && (af != 52'd0))
          || ((be == ExpOnes) && (bf != 52'd0));
    ps = x_i[63] ^ a_i[63] ^ op_i[OpNegProductBit];
    bs = b_i[63] ^ op_i[OpNegAddendBit];
    mx = {xe != 11'd0, xf};
    ma = {ae != 11'd0, af};
  end

  // Decode special results and form partial products
  always_comb begin
    s1_d.spec.hit  = 1'b1;
    s1_d.spec.bits = QnanBits;
    if (anynan) begin
      s1_d.spec.bits = QnanBits;
    end else if (xi || ai) begin
      if (xz || az || (bi && (bs != ps))) s1_d.spec.bits = QnanBits;
      else s1_d.spec.bits = {ps, InfMag};
    end else if (bi) begin
      s1_d.spec.bits = {bs, InfMag};
    end else if (xz || az) begin
      if (bz) s1_d.spec.bits = {ps & bs, 63'd0};
      else s1_d.spec.bits = {bs, b_i[62:0]};
    end else begin
      s1_d.spec.hit = 1'b0;
    end
    s1_d.ps = ps;
    s1_d.bs = bs;
    s1_d.bz = bz;
    s1_d.mb = {be != 11'd0, bf};
    s1_d.ex = (xe != 11'd0) ? xe : 11'd1;
    s1_d.ea = (ae != 11'd0) ? ae : 11'd1;
    s1_d.eb = (be != 11'd0) ? be : 11'd1;
    s1_d.ll = 54'(mx[26:0]) * 54'(ma[26:0]);
    s1_d.lh = 53'(mx[26:0]) * 53'(ma[52:27]);
    s1_d.hl = 53'(mx[52:27]) * 53'(ma[26:0]);
    s1_d.hh = 52'(mx[52:27]) * 52'(ma[52:27]);
  end

  // Sum partial products and work out alignment
  logic [53:0]            mid;
  logic [11:0]            esum;
  logic signed [ExpW-1:0] sdist, tdist;
  logic [6:0]             tsh;

  always_comb begin
    mid     = {1'b0, s1_q.lh} + {1'b0, s1_q.hl};
    s2_d.prod = {s1_q.hh, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, s1_q.ll};
    esum    = {1'b0, s1_q.ex} + {1'b0, s1_q.ea};
    sdist   = $signed({2'b0, esum}) - $signed({3'b0, s1_q.eb}) - 14'sd967;
    tdist   = 14'sd968 - $signed({2'b0, esum});
    if (!s1_q.bz || (tdist <= 14'sd0)) tsh = 7'd0;
    else if (tdist > 14'sd108) tsh = 7'd108;
    else tsh = tdist[6:0];
    s2_d.spec    = s1_q.spec;
    s2_d.ps      = s1_q.ps;
    s2_d.bs      = s1_q.bs;
    s2_d.bz      = s1_q.bz;
    s2_d.eff_sub = (s1_q.ps ^ s1_q.bs) & !s1_q.bz;
    s2_d.clamp   = !s1_q.bz && (sdist < 14'sd0);
    s2_d.mb      = s1_q.mb;
    s2_d.sh_b    = (sdist > 14'sd163) ? 8'd164 : sdist[7:0];
    s2_d.sh_p    = tsh;
    if (s2_d.clamp) s2_d.fe = $signed({3'b0, s1_q.eb}) - 14'sd1185;
    else s2_d.fe = $signed({2'b0, esum}) - 14'sd2152 + $signed({7'b0, tsh});
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Hold or load payload
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
  end

  assign out_valid_o = v2_q;
  assign out_o       = s2_q;

`ifndef SYNTHESIS
  a_prod_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !s2_q.spec.hit) |-> (s2_q.prod != '0))
    else $error("product of finite nonzero operands is zero");
`endif

endmodule

// ===== rtl/vfma_add.sv =====
// Addend/product alignment with sticky collection, then exact add or subtract.
// Depends on vfma_pkg.
module vfma_add import vfma_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  prod_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output sum_t  out_o
);

  typedef struct packed {
    spec_t                  spec;
    logic                   ps;
    logic                   bs;
    logic                   eff_sub;
    logic                   st;
    logic signed [ExpW-1:0] fe;
    logic [FrameW-1:0]      af;
    logic [FrameW-1:0]      pf;
  } s3_t;

  logic v3_q, v4_q, en3, en4;
  s3_t  s3_d, s3_q;
  sum_t s4_d, s4_q;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  // Align addend and product in the frame
  logic [FrameW-1:0] a_full, p_full;
  logic [7:0]        nb;
  logic              lost_b, lost_p;

  always_comb begin
    a_full = {1'b0, in_i.mb, 110'd0};
    p_full = {56'd0, in_i.prod, 2'b00};
    nb     = in_i.sh_b - 8'd110;
    lost_b = (in_i.sh_b > 8'd110) && ((in_i.mb & ~({MantW{1'b1}} << nb)) != '0);
    lost_p = (({in_i.prod, 2'b00} & ~({(ProdW + 2){1'b1}} << in_i.sh_p)) != '0);
    s3_d.spec    = in_i.spec;
    s3_d.ps      = in_i.ps;
    s3_d.bs      = in_i.bs;
    s3_d.eff_sub = in_i.eff_sub;
    s3_d.fe      = in_i.fe;
    s3_d.af      = in_i.clamp ? a_full : (a_full >> in_i.sh_b);
    s3_d.pf      = in_i.clamp ? '0 : (p_full >> in_i.sh_p);
    s3_d.st      = in_i.clamp | lost_b | lost_p;
  end

  // Add, or subtract the smaller side; a dropped operand borrows one
  logic [FrameW:0] d1, d2;

  always_comb begin
    d1 = {1'b0, s3_q.af} - {1'b0, s3_q.pf} - {{FrameW{1'b0}}, s3_q.st};
    d2 = {1'b0, s3_q.pf} - {1'b0, s3_q.af} - {{FrameW{1'b0}}, s3_q.st};
    s4_d.spec = s3_q.spec;
    s4_d.st   = s3_q.st;
    s4_d.fe   = s3_q.fe;
    if (!s3_q.eff_sub) begin
      s4_d.mag  = s3_q.af + s3_q.pf;
      s4_d.sign = s3_q.ps;
    end else if (!d1[FrameW]) begin
      s4_d.mag  = d1[FrameW-1:0];
      s4_d.sign = s3_q.bs;
    end else begin
      s4_d.mag  = d2[FrameW-1:0];
      s4_d.sign = s3_q.ps;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= in_valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  // Hold or load payload
  always_ff @(posedge clk_i) begin
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
  end

  assign out_valid_o = v4_q;
  assign out_o       = s4_q;

endmodule

// ===== rtl/vfma_norm.sv =====
// Leading-zero count in chunks, normalising shift limited by the subnormal floor.
// Depends on vfma_pkg.
module vfma_norm import vfma_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sum_t  in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output norm_t out_o
);

  typedef struct packed {
    sum_t                 sum;
    logic [NumChunks-1:0] nz;
  } s5_t;

  typedef struct packed {
    sum_t       sum;
    logic       zero;
    logic [7:0] lsh;
  } s6_t;

  logic  v5_q, v6_q, v7_q, en5, en6, en7;
  s5_t   s5_d, s5_q;
  s6_t   s6_d, s6_q;
  norm_t s7_d, s7_q;
  logic [3:0] clz_d [NumChunks];
  logic [3:0] clz_q [NumChunks];

  assign en7        = !v7_q || out_ready_i;
  assign en6        = !v6_q || en7;
  assign en5        = !v5_q || en6;
  assign in_ready_o = en5;

  // Count leading zeros per chunk
  logic [PadW-1:0] padded;

  always_comb begin
    padded   = {in_i.mag, {(PadW - FrameW){1'b0}}};
    s5_d.sum = in_i;
    for (int c = 0; c < NumChunks; c++) begin
      s5_d.nz[c] = (padded[PadW-1-ChunkW*c -: ChunkW] != '0);
      clz_d[c]   = lzc16(padded[PadW-1-ChunkW*c -: ChunkW]);
    end
  end

  // Combine chunk counts and limit by the subnormal floor
  logic [7:0]             lz;
  logic signed [ExpW-1:0] lmax;

  always_comb begin
    lz = 8'd0;
    for (int c = NumChunks - 1; c >= 0; c--) begin
      if (s5_q.nz[c]) lz = 8'(ChunkW * c) + {4'd0, clz_q[c]};
    end
    lmax      = 14'sd1185 + s5_q.sum.fe;
    s6_d.sum  = s5_q.sum;
    s6_d.zero = (s5_q.nz == '0);
    if (lmax < 14'sd0) s6_d.lsh = 8'd0;
    else if (lmax < $signed({6'd0, lz})) s6_d.lsh = lmax[7:0];
    else s6_d.lsh = lz;
  end

  // Shift left and form the exponent field
  always_comb begin
    s7_d.spec   = s6_q.sum.spec;
    s7_d.sign   = s6_q.sum.sign;
    s7_d.st     = s6_q.sum.st;
    s7_d.zero   = s6_q.zero;
    s7_d.frame  = s6_q.sum.mag << s6_q.lsh;
    s7_d.efield = 14'sd1185 + s6_q.sum.fe - $signed({6'd0, s6_q.lsh});
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en5) v5_q <= in_valid_i;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // Hold or load payload
  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_q  <= s5_d;
      clz_q <= clz_d;
    end
    if (en6) s6_q <= s6_d;
    if (en7) s7_q <= s7_d;
  end

  assign out_valid_o = v7_q;
  assign out_o       = s7_q;

`ifndef SYNTHESIS
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && !s7_q.spec.hit && !s7_q.zero) |-> (s7_q.frame[FrameW-1] || (s7_q.efield == '0)))
    else $error("normalised frame lacks leading one above the subnormal floor");
`endif

endmodule

// ===== rtl/vfma_round.sv =====
// Round to nearest even, overflow to infinity, pack; holds the output register.
// Depends on vfma_pkg.
module vfma_round import vfma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  norm_t       in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o
);

  logic        v8_q, en8;
  logic [63:0] res_d, res_q;

  assign en8        = !v8_q || out_ready_i;
  assign in_ready_o = en8;

  // Round and pack
  logic [MantW-1:0]       q;
  logic [MantW:0]         qr;
  logic                   guard, sticky, rnd;
  logic signed [ExpW-1:0] etop;
  logic [62:0]            packed_mag;

  always_comb begin
    q          = in_i.frame[FrameW-1 -: MantW];
    guard      = in_i.frame[FrameW-1-MantW];
    sticky     = (in_i.frame[FrameW-2-MantW:0] != '0) | in_i.st;
    rnd        = guard & (sticky | q[0]);
    qr         = {1'b0, q} + {{MantW{1'b0}}, rnd};
    etop       = in_i.efield + $signed({12'd0, qr[MantW:MantW-1]});
    packed_mag = {in_i.efield[10:0], 52'd0} + {9'd0, qr};
    if (in_i.spec.hit) res_d = in_i.spec.bits;
    else if (in_i.zero) res_d = {in_i.st & in_i.sign, 63'd0};
    else if (etop >= 14'sd2047) res_d = {in_i.sign, InfMag};
    else res_d = {in_i.sign, packed_mag};
  end

  // Advance output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en8) v8_q <= in_valid_i;
  end

  // Hold or load result
  always_ff @(posedge clk_i) begin
    if (en8) res_q <= res_d;
  end

  assign out_valid_o = v8_q;
  assign result_o    = res_q;

`ifndef SYNTHESIS
  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v8_q && (res_q[62:52] == ExpOnes) && (res_q[51:0] != '0)) |-> (res_q == QnanBits))
    else $error("NaN result is not the canonical quiet NaN");
`endif

endmodule

// ===== rtl/vector_fused_multiply_add_unit.sv =====
// Binary64 fused multiply-add stream: result = (+-x)*a + (+-b), rounded once to
// nearest even, NaN results canonical. One item is taken every cycle unless a held
// output has filled the stages; each result passes an eight-stage pipeline (two
// multiply, two align/add, three normalise, one round). The stages stall elastically,
// so a held output only stops the stages behind it once they are full.
// Depends on vfma_pkg, vfma_mul, vfma_add, vfma_norm and vfma_round.
module vector_fused_multiply_add_unit import vfma_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // x_bits [63:0], a_bits [127:64], b_bits [191:128]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // result_bits [63:0]
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  logic [1:0]  operation_q, broadcast_q;
  logic [63:0] scalar_a_q, scalar_b_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operation_q <= 2'd0;
      broadcast_q <= 2'd0;
      scalar_a_q  <= 64'd0;
      scalar_b_q  <= 64'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_OPERATION: operation_q <= cfg_data_i[1:0];
        REG_BROADCAST: broadcast_q <= cfg_data_i[1:0];
        REG_SCALAR_A:  scalar_a_q  <= cfg_data_i;
        REG_SCALAR_B:  scalar_b_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Pick per-item or broadcast operands
  logic [63:0] a_sel, b_sel;
  assign a_sel = broadcast_q[BcastABit] ? scalar_a_q : s_axis_tdata[127:64];
  assign b_sel = broadcast_q[BcastBBit] ? scalar_b_q : s_axis_tdata[191:128];

  logic  mul_v, mul_r, add_v, add_r, norm_v, norm_r;
  prod_t mul_o;
  sum_t  add_o;
  norm_t norm_o;

  vfma_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .x_i         (s_axis_tdata[63:0]),
    .a_i         (a_sel),
    .b_i         (b_sel),
    .op_i        (operation_q),
    .out_valid_o (mul_v),
    .out_ready_i (mul_r),
    .out_o       (mul_o)
  );

  vfma_add u_add (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_v),
    .in_ready_o  (mul_r),
    .in_i        (mul_o),
    .out_valid_o (add_v),
    .out_ready_i (add_r),
    .out_o       (add_o)
  );

  vfma_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (add_v),
    .in_ready_o  (add_r),
    .in_i        (add_o),
    .out_valid_o (norm_v),
    .out_ready_i (norm_r),
    .out_o       (norm_o)
  );

  vfma_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_v),
    .in_ready_o  (norm_r),
    .in_i        (norm_o),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (m_axis_tdata)
  );

endmodule

// ===== verif/vector_fused_multiply_add_unit_test.sv =====
// Self-checking testbench of the binary64 fused multiply-add stream unit.
// Predicts each result with an integer FMA model and checks the stream in order.
// Depends on vfma_pkg and vector_fused_multiply_add_unit.
`timescale 1ns / 100ps

module vector_fused_multiply_add_unit_test import vfma_pkg::*;;

  localparam logic [63:0] CanonNan  = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PosInf    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] SignMask  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FracMask  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
  localparam int          IdleLimit = 20000;

  // FMA predictor and ordered store of expected results
  class fma_scoreboard;
    logic [1:0]  op_q;
    logic [1:0]  bcast_q;
    logic [63:0] scal_a_q;
    logic [63:0] scal_b_q;
    logic [63:0] pending_results[$];
    int          n_fail;
    int          n_checked;

    function new();
      op_q = '0; bcast_q = '0; scal_a_q = '0; scal_b_q = '0;
      n_fail = 0; n_checked = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_OPERATION: op_q = val[1:0];
        REG_BROADCAST: bcast_q = val[1:0];
        REG_SCALAR_A:  scal_a_q = val;
        default:       scal_b_q = val;
      endcase
    endfunction

    static function int lead_zeros(logic [127:0] v);
      for (int i = 127; i >= 0; i--) if (v[i]) return 127 - i;
      return 128;
    endfunction

    // Shift right, folding any lost bit into bit 0
    static function logic [127:0] shr_sticky(logic [127:0] v, longint n);
      logic [127:0] r;
      if (n <= 0) return v;
      if (n >= 128) return (v != 0) ? 128'd1 : 128'd0;
      r = v >> n;
      if ((r << n) != v) r[0] = 1'b1;
      return r;
    endfunction

    // Round sign * mag * 2^expo once, nearest even
    static function logic [63:0] round_to_d(logic sign, logic [127:0] mag, longint expo);
      longint top, s;
      logic [127:0] t;
      logic [63:0] q;
      logic lost;
      top = 127 - lead_zeros(mag);
      s = top - 52;
      if (s < -1074 - expo) s = -1074 - expo;
      if (s <= 0) begin
        q = mag[63:0] << (-s);
      end else begin
        t = mag >> (s - 1);
        lost = ((t << (s - 1)) != mag);
        q = t[64:1];
        if (t[0] && (lost || q[0])) q++;
        if (q == (HiddenBit << 1)) begin
          q = q >> 1;
          s++;
        end
      end
      if (q == 0) return {sign, 63'd0};
      if (q >= HiddenBit && expo + s + 1075 >= 2047) return {sign, 63'd0} | PosInf;
      return {sign, 63'd0} + (64'(expo + s + 1074) << 52) + q;
    endfunction

    static function logic [63:0] fma_d(logic [63:0] x, logic [63:0] a, logic [63:0] b,
                                       logic negp, logic negb);
      longint xe, ae, be, pe, qe, d, sh;
      logic [63:0] xf, af, bf;
      logic ps, bs, rs, xz, az, bz, xi, ai, bi;
      logic [127:0] p, q, r;
      xe = x[62:52]; ae = a[62:52]; be = b[62:52];
      xf = x & FracMask; af = a & FracMask; bf = b & FracMask;
      ps = x[63] ^ a[63] ^ negp;
      bs = b[63] ^ negb;
      xz = (xe == 0 && xf == 0); az = (ae == 0 && af == 0); bz = (be == 0 && bf == 0);
      xi = (xe == 2047 && xf == 0); ai = (ae == 2047 && af == 0);
      bi = (be == 2047 && bf == 0);
      if ((xe == 2047 && xf != 0) || (ae == 2047 && af != 0) || (be == 2047 && bf != 0))
        return CanonNan;
      if (xi || ai) begin
        if (xz || az) return CanonNan;
        if (bi && bs != ps) return CanonNan;
        return {ps, 63'd0} | PosInf;
      end
      if (bi) return {bs, 63'd0} | PosInf;
      if (xz || az) begin
        if (bz) return {ps & bs, 63'd0};
        return {bs, b[62:0]};
      end
      p = 128'(xe != 0 ? (xf | HiddenBit) : xf) * 128'(ae != 0 ? (af | HiddenBit) : af);
      pe = (xe != 0 ? xe - 1075 : -1074) + (ae != 0 ? ae - 1075 : -1074);
      sh = lead_zeros(p) - 2;
      p = p << sh;
      pe -= sh;
      if (bz) return round_to_d(ps, p, pe);
      q = 128'(be != 0 ? (bf | HiddenBit) : bf);
      qe = be != 0 ? be - 1075 : -1074;
      sh = lead_zeros(q) - 2;
      q = q << sh;
      qe -= sh;
      d = pe - qe;
      if (d >= 0) q = shr_sticky(q, d);
      else begin
        p = shr_sticky(p, -d);
        pe = qe;
      end
      if (ps == bs) begin
        r = p + q;
        rs = ps;
      end else begin
        if (p == q) return 64'd0;
        if (q > p) begin
          r = q - p;
          rs = bs;
        end else begin
          r = p - q;
          rs = ps;
        end
      end
      return round_to_d(rs, r, pe);
    endfunction

    function void note_input(logic [191:0] item);
      logic [63:0] a, b;
      a = bcast_q[BcastABit] ? scal_a_q : item[127:64];
      b = bcast_q[BcastBBit] ? scal_b_q : item[191:128];
      pending_results.push_back(fma_d(item[63:0], a, b, op_q[OpNegProductBit],
                                      op_q[OpNegAddendBit]));
    endfunction

    function void check_result(logic [63:0] got);
      logic [63:0] want;
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("result_bits: unexpected result %h", got);
        n_fail++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        $error("result_bits: expected %h, actual %h", want, got);
        n_fail++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;   // x_bits [63:0], a_bits [127:64], b_bits [191:128]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // result_bits [63:0]
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;

  fma_scoreboard sb = new();
  bit  hold_off = 0;
  int  idle_cycles = 0;
  int  n_sent = 0;

  vector_fused_multiply_add_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Note transfers on both sides, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (!s_axis_tvalid && sb.pending_results.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 0;
      end
      g = gap_len();
      if (g == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  // Random binary64 operand weighted toward special encodings
  function automatic logic [63:0] rand_fp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'h000;
      2: v[62:0] = '0;
      3: v[62:52] = 11'($urandom_range(1, 60));
      4: v[62:52] = 11'($urandom_range(1990, 2046));
      default: v[62:52] = 11'($urandom_range(900, 1150));
    endcase
    return v;
  endfunction

  task automatic send_item(logic [63:0] x, logic [63:0] a, logic [63:0] b, bit gaps);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a, x};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [63:0] one, dmin, dmax, snan;
    one  = 64'h3FF0_0000_0000_0000;
    dmin = 64'h0000_0000_0000_0001;
    dmax = 64'h7FEF_FFFF_FFFF_FFFF;
    snan = 64'h7FF0_0000_0000_0001;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: signed zeros, NaNs, invalid, overflow, underflow, cancellation
    for (int op = 0; op < 4; op++) begin
      write_reg(REG_OPERATION, 64'(op));
      send_item(64'd0, one, SignMask, 0);
      send_item(SignMask, one, SignMask, 0);
      send_item(one, one, one, 0);
      send_item(PosInf, one, PosInf, 0);
      send_item(dmax, dmax, dmin, 0);
      drain();
    end
    write_reg(REG_OPERATION, 64'd0);
    send_item(snan, one, one, 0);
    send_item(one, CanonNan, one, 0);
    send_item(PosInf, 64'd0, one, 0);
    send_item(dmin, 64'h3FE0_0000_0000_0000, 64'd0, 0);
    send_item(dmin, dmin, SignMask, 0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '1, 0);
    drain();

    // Random phases: every broadcast mode, random operation and scalar registers
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_OPERATION, 64'($urandom_range(0, 3)));
      write_reg(REG_BROADCAST, 64'(ph % 4));
      write_reg(REG_SCALAR_A, ph == 3 ? '1 : rand_fp());
      write_reg(REG_SCALAR_B, ph == 3 ? 64'd0 : rand_fp());
      if (ph == 5) hold_off = 1;
      for (int i = 0; i < 72; i++) send_item(rand_fp(), rand_fp(), rand_fp(), ph != 5);
      drain();
    end

    $display("Covered %0d items over four operations, four broadcast modes,", n_sent);
    $display("special encodings, subnormals and a full-pipeline stall; %0d results checked.",
             sb.n_checked);
    if (sb.n_fail == 0 && sb.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vfma_pkg.sv
rtl/vfma_mul.sv
rtl/vfma_add.sv
rtl/vfma_norm.sv
rtl/vfma_round.sv
rtl/vector_fused_multiply_add_unit.sv
verif/vector_fused_multiply_add_unit_test.sv
